@@ rtl/sca_pkg.sv @@
// Shared types, constants and SHA-256 helper functions for the attestation chain.
package sca_pkg;

  // Request types carried on req_type.
  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_RECORD = 2'd1,
    REQ_FINAL  = 2'd2,
    REQ_NONE   = 2'd3
  } sca_req_t;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REC_IDLE = 2'd1;
  localparam logic [1:0] ST_FIN_IDLE = 2'd2;

  // Domain labels as ASCII byte strings.
  localparam logic [191:0] LABEL_SESSION =
    192'h6370_7269_736b_2e61_7474_6573_742e_7365_7373_696f_6e2e_7631;
  localparam logic [159:0] LABEL_TAG =
    160'h6370_7269_736b_2e61_7474_6573_742e_7461_672e_7631;

  // Register map and key size.
  localparam int KEY_WORDS = 4;
  localparam int ADDR_W    = 5;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic start;
    logic init;
  } sca_ctl_t;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ rtl/sca_sha_core.sv @@
// SHA-256 compression core: one round per cycle with a rolling message schedule.
module sca_sha_core import sca_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  sca_ctl_t       ctl,
  input  logic [511:0]   block,
  output logic           done,
  output logic           busy,
  output logic [255:0]   digest
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_ADD  = 3'b100
  } core_state_t;

  core_state_t state;
  logic [5:0]  rnd;
  logic [31:0] hv [8];
  logic [31:0] v  [8];
  logic [31:0] w  [16];
  logic [31:0] t1, t2, w_new;

  // Round function and next schedule word.
  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[rnd] + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
  end

  // Sequencing of the 64 rounds and the final chaining add.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (ctl.start) begin
            for (int i = 0; i < 8; i++) begin
              if (ctl.init) begin
                hv[i] <= SHA_IV[255 - 32*i -: 32];
                v[i]  <= SHA_IV[255 - 32*i -: 32];
              end else begin
                v[i] <= hv[i];
              end
            end
            for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
            rnd   <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) state <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + v[i];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign busy   = (state != C_IDLE);
  assign digest = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};

endmodule

@@ rtl/sha256_chain_attestation.sv @@
// Top level of the SHA-256 hash chain with HMAC-SHA256 session tag.
// Requests arrive on in_valid/in_ready; results leave on out_valid/out_ready.
// A begin request hashes one 64-byte block, a record two blocks and a
// finalize five blocks (HMAC inner and outer passes). Each block goes through
// a start cycle, 64 rounds on the single shared compression core, one
// chaining add and the hand-back of the digest. Begin and record give one
// result; finalize gives four, one tag word each. Requests without an open
// session are answered without hashing: the result is valid the cycle
// after acceptance.
// in_ready is low from acceptance until the last result of the request is
// taken and rises the cycle after; a stalled receiver simply holds the block
// with the result shown.
// Reset clears the session, hash, count, nonce and the HMAC key registers.
// The key is written over the APB port at byte addresses 0, 8, 16 and 24;
// the user must write it only while the block is idle; the block does not enforce this.
module sha256_chain_attestation import sca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [63:0]        nonce_hi,
  input  logic [63:0]        nonce_lo,
  input  logic [7:0]         det_id,
  input  logic signed [31:0] score,
  input  logic               methods_present,
  input  logic [63:0]        methods_w0,
  input  logic [63:0]        methods_w1,
  input  logic [63:0]        methods_w2,
  input  logic [63:0]        methods_w3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [63:0]        tag_word,
  output logic [1:0]         word_index,
  output logic [31:0]        record_total,
  output logic               last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t       state;
  sca_req_t     op;
  logic [2:0]   phase;
  logic [1:0]   status_q;
  logic [1:0]   idx;
  logic [63:0]  key [KEY_WORDS];
  logic [255:0] chain_hash;
  logic [127:0] session_nonce;
  logic [31:0]  record_count;
  logic         session_active;
  logic [7:0]   rec_id;
  logic [31:0]  rec_score;
  logic [255:0] rec_methods;
  logic [255:0] inner;
  logic [511:0] block;
  logic [255:0] key_all;
  logic         last_phase;
  logic         tag_ok;
  sca_ctl_t     ctl;
  logic         core_done;
  logic         core_busy;
  logic [255:0] digest;

  // Configuration port: writes on the access phase, reads decode directly.
  assign pready  = 1'b1;
  assign prdata  = key[paddr[ADDR_W-1:3]];
  assign key_all = {key[0], key[1], key[2], key[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) key[i] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      key[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  // Message block for the current phase of the current request.
  always_comb begin
    block = '0;
    unique case ({op, phase})
      {REQ_BEGIN, 3'd0}:
        block = {LABEL_SESSION, session_nonce, 8'h80, 120'd0, 64'd320};
      {REQ_RECORD, 3'd0}:
        block = {chain_hash, rec_id, 24'd0, rec_score[7:0], rec_score[15:8],
                 rec_score[23:16], rec_score[31:24], rec_methods[255:64]};
      {REQ_RECORD, 3'd1}:
        block = {rec_methods[63:0], 8'h80, 376'd0, 64'd576};
      {REQ_FINAL, 3'd0}:
        block = {key_all ^ {32{8'h36}}, {32{8'h36}}};
      {REQ_FINAL, 3'd1}:
        block = {LABEL_TAG, 32'd0, session_nonce, chain_hash[255:64]};
      {REQ_FINAL, 3'd2}:
        block = {chain_hash[63:0], record_count[7:0], record_count[15:8],
                 record_count[23:16], record_count[31:24], 8'h80, 344'd0, 64'd1120};
      {REQ_FINAL, 3'd3}:
        block = {key_all ^ {32{8'h5c}}, {32{8'h5c}}};
      {REQ_FINAL, 3'd4}:
        block = {inner, 8'h80, 184'd0, 64'd768};
      default: block = '0;
    endcase
  end

  // The last block of each request type.
  always_comb begin
    case (op)
      REQ_BEGIN:  last_phase = (phase == 3'd0);
      REQ_RECORD: last_phase = (phase == 3'd1);
      default:    last_phase = (phase == 3'd4);
    endcase
  end

  assign ctl.start = (state == S_START);
  assign ctl.init  = (phase == 3'd0) || (phase == 3'd3);

  sca_sha_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .block  (block),
    .done   (core_done),
    .busy   (core_busy),
    .digest (digest)
  );

  // Request sequencer and session state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= REQ_BEGIN;
      phase          <= '0;
      status_q       <= ST_OK;
      idx            <= '0;
      chain_hash     <= '0;
      session_nonce  <= '0;
      record_count   <= '0;
      session_active <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= sca_req_t'(req_type);
            phase    <= '0;
            idx      <= '0;
            status_q <= ST_OK;
            unique case (sca_req_t'(req_type))
              REQ_BEGIN: begin
                session_nonce <= {nonce_hi, nonce_lo};
                state         <= S_START;
              end
              REQ_RECORD: begin
                rec_id      <= det_id;
                rec_score   <= score;
                rec_methods <= methods_present ?
                               {methods_w0, methods_w1, methods_w2, methods_w3} : '0;
                if (session_active) begin
                  state <= S_START;
                end else begin
                  status_q <= ST_REC_IDLE;
                  state    <= S_OUT;
                end
              end
              REQ_FINAL: begin
                if (session_active) begin
                  state <= S_START;
                end else begin
                  status_q <= ST_FIN_IDLE;
                  state    <= S_OUT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (core_done) begin
            if (last_phase) begin
              if (op == REQ_BEGIN) begin
                chain_hash     <= digest;
                record_count   <= '0;
                session_active <= 1'b1;
              end else if (op == REQ_RECORD) begin
                chain_hash   <= digest;
                record_count <= record_count + 32'd1;
              end
              state <= S_OUT;
            end else begin
              if (phase == 3'd2) inner <= digest;
              phase <= phase + 3'd1;
              state <= S_START;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (last) begin
              if (tag_ok) begin
                chain_hash     <= '0;
                record_count   <= '0;
                session_active <= 1'b0;
              end
              state <= S_IDLE;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result fields.
  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign tag_ok     = (op == REQ_FINAL) && (status_q == ST_OK);
  assign status     = status_q;
  assign word_index = (op == REQ_FINAL) ? idx : 2'd0;
  assign last       = (op != REQ_FINAL) || (idx == 2'd3);
  assign record_total = tag_ok ? record_count : 32'd0;

  always_comb begin
    tag_word = '0;
    if (tag_ok) begin
      case (idx)
        2'd0:    tag_word = digest[255:192];
        2'd1:    tag_word = digest[191:128];
        2'd2:    tag_word = digest[127:64];
        default: tag_word = digest[63:0];
      endcase
    end
  end

  // The core never runs while a request can be accepted.
  assert property (@(posedge clk) disable iff (rst) core_busy |-> !in_ready)
    else $error("compression core busy while accepting requests");

  // Results are only shown once hashing is over.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !core_busy)
    else $error("result shown while core still running");

  // The last result ends the request.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (!out_valid && in_ready))
    else $error("block did not return to idle after last result");

  // The core only finishes a block the sequencer is waiting for.
  assert property (@(posedge clk) disable iff (rst) core_done |-> (state == S_WAIT))
    else $error("core finished outside of wait state");

endmodule
